// ----- sv/pced_pkg.sv -----
// shared types, constants and helper functions of the percent escape decoder
package pced_pkg;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// up to three output bytes produced by one input item
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            last;
	} pkt_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_DIG  = 2'd2
	} phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic r;
		r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
		    ((c >= 8'h41) && (c <= 8'h46));
		return r;
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			v = c - 8'h30;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

// ----- sv/percent_escape_decoder_core.sv -----
// top level of the percent escape decoder
// usage:
// - input side is a queue write port: a beat (raw byte plus last flag) is taken
//   on a rising edge with push high and full low
// - result side is a queue read port: while empty is low the oldest decoded
//   byte sits on result; it is taken on a rising edge with pop high
// - '%' plus two hex digits decodes to one byte, '+' to a space, all else
//   passes; a broken escape comes out literally, the last flag flushes it
// - a beat taken is written into the packet queue and then loaded into the
//   unpacker register once the unpacker is free; its first result is then
//   offered on the ports
// - throughput: one input beat per cycle while full is low and one result per
//   cycle while pop is high and empty is low; an input beat that expands into
//   two or three bytes keeps the result side busy for one pop per byte, and the
//   two-packet queue between front and back then fills and raises full
// - a stalled receiver only holds the result; input keeps flowing until the
//   packet queue is full
// - reset (arst_n low) drops anything held or queued and returns the escape
//   parser to its idle phase
module percent_escape_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  pced_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output pced_pkg::out_item_t result
);

	// packet handoff between parser and unpacker
	logic           q_push, q_full, q_pop, q_empty;
	pced_pkg::pkt_t q_wr_pkt, q_rd_pkt;

	// input accepted whenever the packet queue has room
	assign full = q_full;

	pced_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_pkt  (q_wr_pkt)
	);

	pced_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_pkt (q_wr_pkt),
		.full   (q_full),
		.rd     (q_pop),
		.empty  (q_empty),
		.rd_pkt (q_rd_pkt)
	);

	// back end holds the current packet and serves one byte per pop
	pced_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pkt   (q_rd_pkt),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ----- sv/pced_front.sv -----
// front end: escape state machine that turns one input beat into a byte packet, or into none while an escape is held
module pced_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pced_pkg::in_item_t item,
	input  logic               q_full,
	output logic               q_push,
	output pced_pkg::pkt_t     q_pkt
);

	pced_pkg::phase_t phase_q, phase_d;
	logic [7:0]       held_q, held_d;
	logic             acc;
	logic [7:0]       b;
	logic             last;
	logic             pl_emit;
	logic [7:0]       pl_byte;
	logic             pl_hold;
	pced_pkg::pkt_t   pkt;

	assign acc  = push && !q_full;
	assign b    = item.in_byte;
	assign last = item.in_last;

	// treatment of a byte on its own, as if nothing were held
	always_comb begin
		pl_emit = 1'b1;
		pl_hold = 1'b0;
		pl_byte = b;
		if (b == pced_pkg::CH_PCT) begin
			if (!last) begin
				pl_emit = 1'b0;
				pl_hold = 1'b1;
			end
		end else if (b == pced_pkg::CH_PLUS) begin
			pl_byte = pced_pkg::CH_SPACE;
		end
	end

	always_comb begin
		pkt      = '0;
		pkt.last = last;
		phase_d  = pced_pkg::PH_IDLE;
		held_d   = held_q;
		case (phase_q)
			pced_pkg::PH_PCT: begin
				if (pced_pkg::is_hex(b)) begin
					if (last) begin
						pkt.bytes[0] = pced_pkg::CH_PCT;
						pkt.bytes[1] = b;
						pkt.cnt      = 2'd2;
					end else begin
						held_d  = b;
						phase_d = pced_pkg::PH_DIG;
					end
				end else begin
					pkt.bytes[0] = pced_pkg::CH_PCT;
					pkt.bytes[1] = pl_byte;
					pkt.cnt      = pl_emit ? 2'd2 : 2'd1;
					if (pl_hold) begin
						phase_d = pced_pkg::PH_PCT;
					end
				end
			end
			pced_pkg::PH_DIG: begin
				if (pced_pkg::is_hex(b)) begin
					pkt.bytes[0] = {pced_pkg::hex_value(held_q), pced_pkg::hex_value(b)};
					pkt.cnt      = 2'd1;
				end else begin
					pkt.bytes[0] = pced_pkg::CH_PCT;
					pkt.bytes[1] = held_q;
					pkt.bytes[2] = pl_byte;
					pkt.cnt      = pl_emit ? 2'd3 : 2'd2;
					if (pl_hold) begin
						phase_d = pced_pkg::PH_PCT;
					end
				end
			end
			default: begin
				pkt.bytes[0] = pl_byte;
				pkt.cnt      = pl_emit ? 2'd1 : 2'd0;
				if (pl_hold) begin
					phase_d = pced_pkg::PH_PCT;
				end
			end
		endcase
		if (last) begin
			phase_d = pced_pkg::PH_IDLE;
			held_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pced_pkg::PH_IDLE;
			held_q  <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	assign q_push = acc && (pkt.cnt != 2'd0);
	assign q_pkt  = pkt;

endmodule

// ----- sv/pced_queue.sv -----
// small register queue of byte packets between front and back
module pced_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  pced_pkg::pkt_t wr_pkt,
	output logic           full,
	input  logic           rd,
	output logic           empty,
	output pced_pkg::pkt_t rd_pkt
);

	pced_pkg::pkt_t               mem_q [pced_pkg::QDEPTH];
	logic [pced_pkg::QAW-1:0]     wp_q, rp_q;
	logic [pced_pkg::QAW:0]       cnt_q;
	logic                         do_wr, do_rd;

	assign full   = (cnt_q == (pced_pkg::QAW+1)'(pced_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_pkt = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == pced_pkg::QAW'(pced_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == pced_pkg::QAW'(pced_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/pced_back.sv -----
// back end: unpacks byte packets into single result beats
module pced_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  pced_pkg::pkt_t      q_pkt,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output pced_pkg::out_item_t result
);

	pced_pkg::pkt_t pkt_q;
	logic           vld_q;
	logic [1:0]     idx_q;
	logic           fin;
	logic           ld;
	logic [7:0]     cur;

	assign fin   = vld_q && pop && (idx_q == pkt_q.cnt - 2'd1);
	assign ld    = !vld_q || fin;
	assign q_pop = ld && !q_empty;
	assign empty = !vld_q;

	always_comb begin
		case (idx_q)
			2'd0:    cur = pkt_q.bytes[0];
			2'd1:    cur = pkt_q.bytes[1];
			default: cur = pkt_q.bytes[2];
		endcase
	end

	assign result.out_byte = cur;
	assign result.out_last = pkt_q.last && (idx_q == pkt_q.cnt - 2'd1);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pkt_q <= q_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (ld) begin
			vld_q <= !q_empty;
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule
